// ----- sv/vector_heading_atan2_defines.svh -----
// Assertion macros for the vector heading block.
`ifndef VECTOR_HEADING_ATAN2_DEFINES_SVH
`define VECTOR_HEADING_ATAN2_DEFINES_SVH

// Checked on every rising edge while out of reset.
`define VHA_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define VHA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/vha_pkg.sv -----
// Shared types, angle constants and arctangent table generator for the heading block.
package vha_pkg;

    localparam int ROM_W = 14;

    localparam logic [15:0] ANGLE_QUARTER = 16'd16384;
    localparam logic [15:0] ANGLE_HALF    = 16'd32768;
    localparam longint unsigned ANGLE_EIGHTH = 64'd8192;

    // Per-transaction control travelling alongside the data
    typedef struct packed {
        logic x_neg;   // delta_x negative
        logic up_neg;  // upward component (-delta_y) negative
        logic swap;    // |dx| > |dy|: index taken from |dy|/|dx|
        logic zero;    // zero vector
    } vha_flags_t;

    // Elaboration-time helpers: shift-subtract division on 64-bit words
    function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
        longint unsigned r;
        longint unsigned q;
        r = 64'd0;
        q = 64'd0;
        for (int k = 63; k >= 0; k--)
        begin
            r = {r[62:0], a[k]};
            if (r >= b)
            begin
                r    = r - b;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // floor(x*m/d) without overflow, m <= d
    function automatic longint unsigned mul_div_floor(longint unsigned x,
                                                      longint unsigned m,
                                                      longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = udiv64(x, d);
        r = x - q * d;
        return q * m + udiv64(r * m, d);
    endfunction

    // atan(i/n) in Q60 radians, Euler series
    function automatic longint unsigned atan_q60(longint unsigned i, longint unsigned n);
        longint unsigned d;
        longint unsigned t;
        longint unsigned sum;
        d   = n * n + i * i;
        t   = mul_div_floor(64'd1 << 60, i * n, d);
        sum = t;
        for (int k = 1; k < 200; k++)
        begin
            if (t != 64'd0)
            begin
                t   = mul_div_floor(t, 64'(2 * k), 64'(2 * k + 1));
                t   = mul_div_floor(t, i * i, d);
                sum = sum + t;
            end
        end
        return sum;
    endfunction

    // Table entry i of n steps: rounded octant angle, n maps to one eighth turn
    function automatic logic [ROM_W-1:0] atan_rom_entry(int i, int n);
        longint unsigned full;
        longint unsigned s;
        longint unsigned v;
        full = atan_q60(64'(n), 64'(n)) >> 20;
        s    = atan_q60(64'(i), 64'(n)) >> 20;
        v    = udiv64(64'd2 * ANGLE_EIGHTH * s + full, 64'd2 * full);
        return v[ROM_W-1:0];
    endfunction

endpackage

// ----- sv/vha_fold.sv -----
// Two-stage front end: saturation, magnitudes, octant fold.
module vha_fold (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  delta_x,
    input  logic signed [31:0]  delta_y,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [30:0]         small_mag,
    output logic [30:0]         large_mag,
    output vha_pkg::vha_flags_t flags
);

    // |v| after saturating -2^31 to -(2^31-1); result fits 31 bits
    function automatic logic [30:0] sat_mag(logic [31:0] v);
        logic [31:0] s;
        logic [31:0] n;
        s = (v == 32'h8000_0000) ? 32'h8000_0001 : v;
        n = ~s + 32'd1;
        return s[31] ? n[30:0] : s[30:0];
    endfunction

    // stage A
    logic        a_valid_reg;
    logic [30:0] ax_reg, ax_next;
    logic [30:0] ay_reg, ay_next;
    logic        a_xneg_reg, a_xneg_next;
    logic        a_upneg_reg, a_upneg_next;
    logic        a_ready;

    // stage B
    logic                b_valid_reg;
    logic [30:0]         small_reg, small_next;
    logic [30:0]         large_reg, large_next;
    vha_pkg::vha_flags_t flags_reg, flags_next;
    logic                b_ready;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        ax_next      = sat_mag(delta_x);
        ay_next      = sat_mag(delta_y);
        a_xneg_next  = delta_x[31];
        a_upneg_next = !delta_y[31] && (delta_y != 32'sd0);
    end

    always_comb
    begin
        flags_next.x_neg  = a_xneg_reg;
        flags_next.up_neg = a_upneg_reg;
        flags_next.swap   = ax_reg > ay_reg;
        small_next        = flags_next.swap ? ay_reg : ax_reg;
        large_next        = flags_next.swap ? ax_reg : ay_reg;
        flags_next.zero   = (large_next == 31'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            ax_reg      <= ax_next;
            ay_reg      <= ay_next;
            a_xneg_reg  <= a_xneg_next;
            a_upneg_reg <= a_upneg_next;
        end
        if (b_ready && a_valid_reg)
        begin
            small_reg <= small_next;
            large_reg <= large_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign small_mag = small_reg;
    assign large_mag = large_reg;
    assign flags     = flags_reg;

endmodule

// ----- sv/vha_divider.sv -----
// Pipelined restoring divider: floor(small*ATAN_STEPS/large), one quotient bit per stage.
module vha_divider #(
    parameter int ATAN_STEPS = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [30:0]            small_mag,
    input  logic [30:0]            large_mag,
    input  vha_pkg::vha_flags_t    in_flags,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [$clog2(ATAN_STEPS+1)-1:0] quotient,
    output vha_pkg::vha_flags_t    out_flags
);

    localparam int QB = $clog2(ATAN_STEPS + 1);
    localparam int PW = 31 + QB;

    // stage 0 forms the dividend, stages 1..QB each resolve one quotient bit
    logic                valid_reg   [QB+1];
    logic                valid_in    [QB+1];
    logic                stage_ready [QB+1];
    logic [QB-1:0]       qd_reg      [QB+1];
    logic [QB-1:0]       qd_next     [QB+1];
    vha_pkg::vha_flags_t flags_reg   [QB+1];
    vha_pkg::vha_flags_t flags_next  [QB+1];
    logic [30:0]         rem_reg     [QB];
    logic [30:0]         rem_next    [QB];
    logic [30:0]         large_reg   [QB];
    logic [30:0]         large_next  [QB];
    logic [PW-1:0]       product;

    // dividend >> QB is below the divisor, so the quotient fits QB bits
    assign product       = PW'(small_mag) * PW'(ATAN_STEPS);
    assign valid_in[0]   = in_valid;
    assign rem_next[0]   = product[PW-1:QB];
    assign qd_next[0]    = product[QB-1:0];
    assign large_next[0] = large_mag;
    assign flags_next[0] = in_flags;

    for (genvar s = 1; s <= QB; s++)
    begin : g_step
        logic [31:0] trial;
        logic [31:0] diff;
        logic        ge;

        assign trial         = {rem_reg[s-1], qd_reg[s-1][QB-1]};
        assign diff          = trial - {1'b0, large_reg[s-1]};
        assign ge            = trial >= {1'b0, large_reg[s-1]};
        assign valid_in[s]   = valid_reg[s-1];
        assign qd_next[s]    = {qd_reg[s-1][QB-2:0], ge};
        assign flags_next[s] = flags_reg[s-1];

        if (s < QB)
        begin : g_carry
            assign rem_next[s]   = ge ? diff[30:0] : trial[30:0];
            assign large_next[s] = large_reg[s-1];
        end
    end

    for (genvar s = 0; s <= QB; s++)
    begin : g_ready
        if (s == QB)
        begin : g_last
            assign stage_ready[s] = !valid_reg[s] || out_ready;
        end
        else
        begin : g_mid
            assign stage_ready[s] = !valid_reg[s] || stage_ready[s+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= QB; s++)
                valid_reg[s] <= 1'b0;
        end
        else
        begin
            for (int s = 0; s <= QB; s++)
                if (stage_ready[s])
                    valid_reg[s] <= valid_in[s];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= QB; s++)
        begin
            if (stage_ready[s] && valid_in[s])
            begin
                qd_reg[s]    <= qd_next[s];
                flags_reg[s] <= flags_next[s];
            end
        end
        // the last stage carries no remainder
        for (int s = 0; s < QB; s++)
        begin
            if (stage_ready[s] && valid_in[s])
            begin
                rem_reg[s]   <= rem_next[s];
                large_reg[s] <= large_next[s];
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[QB];
    assign quotient  = qd_reg[QB];
    assign out_flags = flags_reg[QB];

endmodule

// ----- sv/vha_unfold.sv -----
// Arctangent table lookup and octant/quadrant unfold, two stages.
module vha_unfold #(
    parameter int ATAN_STEPS = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [$clog2(ATAN_STEPS+1)-1:0] quotient,
    input  vha_pkg::vha_flags_t    in_flags,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [15:0]            heading
);

    localparam int QB = $clog2(ATAN_STEPS + 1);
    localparam int RW = vha_pkg::ROM_W;

    logic [RW-1:0] rom_table [ATAN_STEPS+1];

    for (genvar g = 0; g <= ATAN_STEPS; g++)
    begin : g_rom
        localparam logic [RW-1:0] ENTRY = vha_pkg::atan_rom_entry(g, ATAN_STEPS);
        assign rom_table[g] = ENTRY;
    end

    // stage R: table read
    logic                r_valid_reg;
    logic                r_ready;
    logic [QB-1:0]       index;
    logic [RW-1:0]       oct_reg, oct_next;
    vha_pkg::vha_flags_t r_flags_reg;

    // stage H: unfold
    logic                h_valid_reg;
    logic                h_ready;
    logic [15:0]         base;
    logic [15:0]         heading_reg, heading_next;

    assign h_ready  = !h_valid_reg || out_ready;
    assign r_ready  = !r_valid_reg || h_ready;
    assign in_ready = r_ready;

    always_comb
    begin
        index    = (quotient > QB'(ATAN_STEPS)) ? QB'(ATAN_STEPS) : quotient;
        oct_next = in_flags.zero ? '0 : rom_table[index];
    end

    always_comb
    begin
        base = r_flags_reg.swap ? 16'(vha_pkg::ANGLE_QUARTER - 16'(oct_reg))
                                : 16'(oct_reg);
        case ({r_flags_reg.x_neg, r_flags_reg.up_neg})
            2'b00:   heading_next = base;
            2'b01:   heading_next = vha_pkg::ANGLE_HALF - base;
            2'b11:   heading_next = vha_pkg::ANGLE_HALF + base;
            default: heading_next = 16'd0 - base;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end
        else
        begin
            if (r_ready)
                r_valid_reg <= in_valid;
            if (h_ready)
                h_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_ready && in_valid)
        begin
            oct_reg     <= oct_next;
            r_flags_reg <= in_flags;
        end
        if (h_ready && r_valid_reg)
            heading_reg <= heading_next;
    end

    assign out_valid = h_valid_reg;
    assign heading   = heading_reg;

endmodule

// ----- sv/vector_heading_atan2.sv -----
// Top level of the screen-space vector heading unit (binary-angle atan2).
//
// Usage:
//   Input channel: in_valid/in_ready carry one transaction of (delta_x, delta_y),
//   signed 32-bit, +y toward the screen bottom. Output channel: out_valid/out_ready
//   carry the 16-bit heading, 65536 per turn, 0 = up, growing clockwise toward +x.
//   Pipeline stages: two fold stages, one dividend stage, one divider stage per
//   quotient bit, a table stage and an unfold stage.
//   Throughput: one transaction per cycle while the receiver keeps out_ready high;
//   the bit-per-stage divider sets the depth, not the rate.
//   Reset (rst_n low, asynchronous) empties every stage; in_ready is high and
//   out_valid low straight after. The arctangent table is constant logic built
//   at elaboration and needs no loading.
//   Receiver stall: the last stage holds its heading; earlier stages keep filling
//   any empty slot, so in_ready drops only once every stage holds a transaction.
//   Zero vectors give heading 0; -2^31 on either input is treated as -(2^31-1).
module vector_heading_atan2 #(
    parameter int ATAN_STEPS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] delta_x,
    input  logic signed [31:0] delta_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        heading
);

    localparam int QB = $clog2(ATAN_STEPS + 1);

    // fold -> divider
    logic                fold_valid;
    logic                div_ready;
    logic [30:0]         small_mag;
    logic [30:0]         large_mag;
    vha_pkg::vha_flags_t fold_flags;

    // divider -> unfold
    logic                div_valid;
    logic                unfold_ready;
    logic [QB-1:0]       quotient;
    vha_pkg::vha_flags_t div_flags;

    // magnitudes and octant choice
    vha_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .delta_x   (delta_x),
        .delta_y   (delta_y),
        .out_valid (fold_valid),
        .out_ready (div_ready),
        .small_mag (small_mag),
        .large_mag (large_mag),
        .flags     (fold_flags)
    );

    // table index = floor(small * ATAN_STEPS / large)
    vha_divider #(
        .ATAN_STEPS (ATAN_STEPS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fold_valid),
        .in_ready  (div_ready),
        .small_mag (small_mag),
        .large_mag (large_mag),
        .in_flags  (fold_flags),
        .out_valid (div_valid),
        .out_ready (unfold_ready),
        .quotient  (quotient),
        .out_flags (div_flags)
    );

    // octant angle, then back to the full circle
    vha_unfold #(
        .ATAN_STEPS (ATAN_STEPS)
    ) u_unfold (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (unfold_ready),
        .quotient  (quotient),
        .in_flags  (div_flags),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .heading   (heading)
    );

endmodule

// ----- sv/vha_checker.sv -----
// Port-level assertion checker for the vector heading unit, with its bind.
`include "vector_heading_atan2_defines.svh"

module vha_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [15:0]        heading
);

    // reset empties the pipeline by the next edge
    `VHA_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_valid && in_ready), "pipeline not empty in reset")

    // a ready receiver lets every stage move, so the input side is open
    `VHA_ASSERT_CLK(a_ready_through, out_ready |-> in_ready, "in_ready low with out_ready high")

    // input held off only when the pipe is full, hence a result is on offer
    `VHA_ASSERT_CLK(a_full_has_result, !in_ready |-> out_valid, "in_ready low without a result")

    // stalled result holds
    `VHA_ASSERT_CLK(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(heading)), "stalled heading changed")

endmodule

bind vector_heading_atan2 vha_checker u_checker (.*);
